/* sv/hdpq_pkg.sv */
`timescale 1ns / 1ps
package hdpq_pkg;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_RETIRE = 2'd1,
        OP_TICK   = 2'd2,
        OP_PULL   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_SIZE = 2'd1,
        ST_FULL = 2'd2
    } status_t;

    localparam logic [1:0] CFG_FILTER  = 2'd0;
    localparam logic [1:0] CFG_LIMIT   = 2'd1;
    localparam logic [1:0] CFG_BLOCK   = 2'd2;
    localparam logic [1:0] CFG_LATENCY = 2'd3;

    typedef struct packed {
        logic [1:0]  operation;
        logic [63:0] pc_value;
        logic [63:0] hint_address;
        logic [12:0] hint_bytes;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        issue_valid;
        logic [63:0] issue_address;
        logic [12:0] issue_size;
        logic [63:0] issue_pc;
        logic [10:0] hints_matched;
        logic [15:0] segments_queued;
        logic [15:0] segments_skipped;
        logic [15:0] segments_dropped;
    } out_item_t;

    typedef struct packed {
        logic        filter;
        logic [5:0]  limit;
        logic [3:0]  shift;
        logic [7:0]  latency;
    } cfg_t;

endpackage

/* sv/hint_driven_prefetch_queue.sv */
`timescale 1ns / 1ps
// channel   | signals                            | beat
// in        | in_valid, in_ready, in_data        | one command
// out       | out_valid, out_ready, out_data     | one result per command
// cfg       | cfg_we, cfg_index, cfg_data        | one register write
// a retire walks the hint table for hints whose pc matches and splits each
// into line segments; with the line filter on, each segment also scans the
// queued entries. all state resets at once; hint and segment stores are not
// cleared. a two-beat command queue lets input run ahead while the result
// register waits on out_ready.
module hint_driven_prefetch_queue #(
    parameter int HINT_DEPTH     = 1024,
    parameter int QUEUE_DEPTH    = 32,
    parameter int MAX_HINT_BYTES = 4096
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  hdpq_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output hdpq_pkg::out_item_t out_data,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [7:0]          cfg_data
);
    import hdpq_pkg::*;

    cfg_t       cfg_reg;
    logic       cmd_valid, cmd_ready, busy;
    in_item_t   cmd_data;
    logic [1:0] cmd_bad;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.filter <= 1'b1;
            cfg_reg.limit <= 6'd32;
            cfg_reg.shift <= 4'd6;
            cfg_reg.latency <= 8'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FILTER:  cfg_reg.filter <= cfg_data[0];
                CFG_LIMIT:   cfg_reg.limit <= cfg_data[5:0];
                CFG_BLOCK:   cfg_reg.shift <= cfg_data[3:0];
                default:     cfg_reg.latency <= cfg_data;
            endcase
        end
    end

    hdpq_front #(.MAX_HINT_BYTES(MAX_HINT_BYTES)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd_data(cmd_data),
        .cmd_bad(cmd_bad)
    );

    hdpq_back #(.HINT_DEPTH(HINT_DEPTH), .QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
        .clk(clk), .rst_n(rst_n), .cfg(cfg_reg),
        .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd_data(cmd_data),
        .cmd_bad(cmd_bad),
        .res_valid(out_valid), .res_ready(out_ready), .res_data(out_data),
        .busy(busy)
    );

`ifndef SYNTHESIS
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result beat dropped or changed while stalled");
    a_issue_only_pull: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.issue_valid |->
            out_data.status == ST_OK && out_data.hints_matched == 11'd0)
        else $error("issue on non-pull");
    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |-> !busy)
        else $error("register write while a command is in flight");
`endif

endmodule

/* sv/hdpq_front.sv */
`timescale 1ns / 1ps
module hdpq_front #(
    parameter int MAX_HINT_BYTES = 4096
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  hdpq_pkg::in_item_t in_data,
    output logic               cmd_valid,
    input  logic               cmd_ready,
    output hdpq_pkg::in_item_t cmd_data,
    output logic [1:0]         cmd_bad
);
    import hdpq_pkg::*;

    // two-entry command queue with pre-classification of load size
    in_item_t   q_data_reg [2];
    logic [1:0] q_bad_reg [2];
    logic       q_wp_reg, q_rp_reg;
    logic [1:0] q_cnt_reg;
    logic [64:0] sum;
    logic        bad;
    logic        push, pop;

    assign sum = {1'b0, in_data.hint_address} + 65'(in_data.hint_bytes);
    assign bad = (in_data.hint_bytes == 13'd0) ||
                 (32'(in_data.hint_bytes) > 32'(MAX_HINT_BYTES)) || sum[64];
    assign in_ready = (q_cnt_reg != 2'd2);
    assign push = in_valid && in_ready;
    assign pop = cmd_valid && cmd_ready;
    assign cmd_valid = (q_cnt_reg != 2'd0);
    assign cmd_data = q_data_reg[q_rp_reg];
    assign cmd_bad = q_bad_reg[q_rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_data_reg[q_wp_reg] <= in_data;
            q_bad_reg[q_wp_reg] <= bad ? ST_SIZE : ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_wp_reg <= 1'b0;
            q_rp_reg <= 1'b0;
            q_cnt_reg <= 2'd0;
        end
        else
        begin
            if (push) q_wp_reg <= ~q_wp_reg;
            if (pop) q_rp_reg <= ~q_rp_reg;
            q_cnt_reg <= q_cnt_reg + 2'(push) - 2'(pop);
        end
    end
endmodule

/* sv/hdpq_back.sv */
`timescale 1ns / 1ps
module hdpq_back #(
    parameter int HINT_DEPTH  = 1024,
    parameter int QUEUE_DEPTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  hdpq_pkg::cfg_t      cfg,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  hdpq_pkg::in_item_t  cmd_data,
    input  logic [1:0]          cmd_bad,
    output logic                res_valid,
    input  logic                res_ready,
    output hdpq_pkg::out_item_t res_data,
    output logic                busy
);
    import hdpq_pkg::*;

    localparam int HW = $clog2(HINT_DEPTH);
    localparam int CW = $clog2(HINT_DEPTH + 1);
    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_HREAD = 8'b00000010,
        S_HCHK  = 8'b00000100,
        S_SEG   = 8'b00001000,
        S_SCAN  = 8'b00010000,
        S_DECIDE= 8'b00100000,
        S_PULL  = 8'b01000000,
        S_DONE  = 8'b10000000
    } state_t;

    state_t state_reg;

    logic [63:0] hpc_mem [HINT_DEPTH];
    logic [63:0] had_mem [HINT_DEPTH];
    logic [12:0] hln_mem [HINT_DEPTH];
    logic [63:0] hpc_rd_reg, had_rd_reg;
    logic [12:0] hln_rd_reg;

    logic [63:0] sad_mem [QUEUE_DEPTH];
    logic [12:0] sln_mem [QUEUE_DEPTH];
    logic [63:0] spc_mem [QUEUE_DEPTH];
    logic [31:0] srd_mem [QUEUE_DEPTH];

    logic [CW-1:0] fill_reg, cursor_reg;
    logic [QW-1:0] head_reg;
    logic [NW-1:0] count_reg;
    logic [31:0]   now_reg;

    in_item_t    cmd_reg;
    out_item_t   res_reg;
    out_item_t   res_init;
    logic        res_valid_reg;
    logic [63:0] seg_addr_reg;
    logic [12:0] remain_reg;
    logic [12:0] seg_len_reg;
    logic [NW-1:0] scan_reg;
    logic        hit_reg;

    logic [3:0]  sh;
    logic [12:0] line_mask;
    logic [13:0] room;
    logic [12:0] seg_len;
    logic [QW-1:0] scan_slot, tail_slot;
    logic [NW-1:0] limit;
    logic [32:0] ready_sum;
    logic [NW:0] hs, ht;

    assign sh = (cfg.shift < 4'd4) ? 4'd4 : ((cfg.shift > 4'd12) ? 4'd12 : cfg.shift);
    assign line_mask = 13'((14'd1 << sh) - 14'd1);
    assign room = (14'd1 << sh) - 14'(seg_addr_reg[12:0] & line_mask);
    assign seg_len = (room < 14'(remain_reg)) ? room[12:0] : remain_reg;
    assign hs = (NW+1)'(head_reg) + (NW+1)'(scan_reg);
    assign ht = (NW+1)'(head_reg) + (NW+1)'(count_reg);
    assign scan_slot = (hs >= (NW+1)'(QUEUE_DEPTH)) ?
                       QW'(hs - (NW+1)'(QUEUE_DEPTH)) : QW'(hs);
    assign tail_slot = (ht >= (NW+1)'(QUEUE_DEPTH)) ?
                       QW'(ht - (NW+1)'(QUEUE_DEPTH)) : QW'(ht);
    assign limit = (32'(cfg.limit) < 32'(QUEUE_DEPTH)) ? NW'(cfg.limit) : NW'(QUEUE_DEPTH);
    assign ready_sum = {1'b0, now_reg} + 33'(cfg.latency);

    assign cmd_ready = (state_reg == S_IDLE) && !res_valid_reg;
    assign res_valid = res_valid_reg;
    assign res_data = res_reg;
    assign busy = (state_reg != S_IDLE) || res_valid_reg;

    function automatic logic [15:0] inc16(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    always_comb
    begin
        res_init = '0;
        if (cmd_data.operation == OP_LOAD)
        begin
            if (cmd_bad != ST_OK)
                res_init.status = ST_SIZE;
            else if (fill_reg >= CW'(HINT_DEPTH))
                res_init.status = ST_FULL;
        end
    end

    // hint table memory
    always_ff @(posedge clk)
    begin
        if (cmd_valid && cmd_ready && cmd_data.operation == OP_LOAD &&
            cmd_bad == ST_OK && fill_reg < CW'(HINT_DEPTH))
        begin
            hpc_mem[HW'(fill_reg)] <= cmd_data.pc_value;
            had_mem[HW'(fill_reg)] <= cmd_data.hint_address;
            hln_mem[HW'(fill_reg)] <= cmd_data.hint_bytes;
        end
        hpc_rd_reg <= hpc_mem[HW'(cursor_reg)];
        had_rd_reg <= had_mem[HW'(cursor_reg)];
        hln_rd_reg <= hln_mem[HW'(cursor_reg)];
    end

    // segment queue storage
    always_ff @(posedge clk)
    begin
        if (state_reg == S_DECIDE && !hit_reg && count_reg < limit)
        begin
            sad_mem[tail_slot] <= seg_addr_reg;
            sln_mem[tail_slot] <= seg_len_reg;
            spc_mem[tail_slot] <= cmd_reg.pc_value;
            srd_mem[tail_slot] <= ready_sum[32] ? 32'hFFFFFFFF : ready_sum[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fill_reg <= '0;
            cursor_reg <= '0;
            head_reg <= '0;
            count_reg <= '0;
            now_reg <= '0;
            res_valid_reg <= 1'b0;
            cmd_reg <= '0;
            res_reg <= '0;
            seg_addr_reg <= '0;
            remain_reg <= '0;
            seg_len_reg <= '0;
            scan_reg <= '0;
            hit_reg <= 1'b0;
        end
        else
        begin
            if (res_valid_reg && res_ready) res_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid && cmd_ready)
                    begin
                        cmd_reg <= cmd_data;
                        res_reg <= res_init;
                        unique case (op_t'(cmd_data.operation))
                            OP_LOAD:
                            begin
                                if (cmd_bad == ST_OK && fill_reg < CW'(HINT_DEPTH))
                                    fill_reg <= fill_reg + CW'(1);
                                state_reg <= S_DONE;
                            end
                            OP_RETIRE: state_reg <= S_HREAD;
                            OP_TICK:
                            begin
                                if (now_reg != 32'hFFFFFFFF) now_reg <= now_reg + 32'd1;
                                state_reg <= S_DONE;
                            end
                            default: state_reg <= S_PULL;
                        endcase
                    end
                end
                S_HREAD: state_reg <= S_HCHK;
                S_HCHK:
                begin
                    if (cursor_reg < fill_reg && hpc_rd_reg == cmd_reg.pc_value)
                    begin
                        seg_addr_reg <= had_rd_reg;
                        remain_reg <= hln_rd_reg;
                        cursor_reg <= cursor_reg + CW'(1);
                        if (res_reg.hints_matched != 11'h7FF)
                            res_reg.hints_matched <= res_reg.hints_matched + 11'd1;
                        state_reg <= S_SEG;
                    end
                    else
                        state_reg <= S_DONE;
                end
                S_SEG:
                begin
                    if (remain_reg == 13'd0)
                        state_reg <= S_HREAD;
                    else
                    begin
                        seg_len_reg <= seg_len;
                        scan_reg <= '0;
                        hit_reg <= 1'b0;
                        state_reg <= cfg.filter ? S_SCAN : S_DECIDE;
                    end
                end
                S_SCAN:
                begin
                    if (scan_reg >= count_reg)
                        state_reg <= S_DECIDE;
                    else
                    begin
                        if ((sad_mem[scan_slot] >> sh) == (seg_addr_reg >> sh))
                        begin
                            hit_reg <= 1'b1;
                            state_reg <= S_DECIDE;
                        end
                        scan_reg <= scan_reg + NW'(1);
                    end
                end
                S_DECIDE:
                begin
                    if (hit_reg)
                        res_reg.segments_skipped <= inc16(res_reg.segments_skipped);
                    else if (count_reg >= limit)
                        res_reg.segments_dropped <= inc16(res_reg.segments_dropped);
                    else
                    begin
                        count_reg <= count_reg + NW'(1);
                        res_reg.segments_queued <= inc16(res_reg.segments_queued);
                    end
                    seg_addr_reg <= seg_addr_reg + 64'(seg_len_reg);
                    remain_reg <= remain_reg - seg_len_reg;
                    state_reg <= S_SEG;
                end
                S_PULL:
                begin
                    if (count_reg != '0 && srd_mem[head_reg] <= now_reg)
                    begin
                        res_reg.issue_valid <= 1'b1;
                        res_reg.issue_address <= sad_mem[head_reg];
                        res_reg.issue_size <= sln_mem[head_reg];
                        res_reg.issue_pc <= spc_mem[head_reg];
                        head_reg <= (head_reg == QW'(QUEUE_DEPTH - 1)) ?
                                    '0 : head_reg + QW'(1);
                        count_reg <= count_reg - NW'(1);
                    end
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    res_valid_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
